// ===== rtl/sfla_pkg.sv =====
`default_nettype none
package sfla_pkg;

  localparam int unsigned SLOT_W = 10;
  localparam int unsigned ADDR_W = 26;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SPS_W = 11;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SIZE_W-1:0] MIN_SLOT_BYTES = 16'd8;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FREED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_MEM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SLAB = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'd1;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] slot_number;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [ADDR_W-1:0]   slot_address;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/slab_free_list_allocator.sv =====
`default_nettype none
// Slab free-list slot allocator. A request is taken when start is high and busy
// is low; its single result appears on rsp with done high for exactly one cycle
// and must be captured then, since the receiver cannot stall the block. A free,
// or an allocate that runs out of memory, goes from idle straight to S_MUL. An
// allocate from a non-empty list first does one registered read of the link
// memory to fetch the new head, then the address multiply. An allocate that
// finds the list empty first formats a new slab, writing one link per cycle
// through the single memory write port, max(slots_per_slab, 1) links in all.
// The link memory needs no clearing after reset.
// Config writes are always ready and must only be issued while the block is idle.
module slab_free_list_allocator #(
  parameter int unsigned POOL_SLOTS = 1024
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  sfla_pkg::req_t                        req,
  output logic                                  done,
  output sfla_pkg::rsp_t                        rsp,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [sfla_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [sfla_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned LINK_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned CMP_W =
    ((LINK_W > sfla_pkg::SPS_W) ? LINK_W : sfla_pkg::SPS_W) + 1;
  localparam int unsigned PROD_W = CMP_W + sfla_pkg::SIZE_W;
  localparam logic [LINK_W-1:0] EMPTY = LINK_W'(POOL_SLOTS);
  localparam logic [CMP_W-1:0] POOL_CMP = CMP_W'(POOL_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FMT  = 5'b00010,
    S_RD   = 5'b00100,
    S_LINK = 5'b01000,
    S_MUL  = 5'b10000
  } state_t;

  state_t state;

  logic [LINK_W-1:0] next_link [POOL_SLOTS];
  logic [LINK_W-1:0] rd_data;

  logic [sfla_pkg::SPS_W-1:0]  slots_per_slab;
  logic [sfla_pkg::SIZE_W-1:0] slot_bytes;
  logic [LINK_W-1:0]           list_head;
  logic [LINK_W-1:0]           slots_formatted;
  logic [LINK_W-1:0]           fmt_addr;
  logic [LINK_W-1:0]           fmt_end;
  logic [CMP_W-1:0]            res_slot;
  logic [sfla_pkg::STATUS_W-1:0] res_status;

  logic [sfla_pkg::SPS_W-1:0]  slab_count;
  logic [CMP_W-1:0]            slab_top;
  logic                        slab_fits;
  logic [CMP_W-1:0]            free_slot;
  logic                        free_in_pool;
  logic [sfla_pkg::SIZE_W-1:0] eff_size;
  logic [PROD_W-1:0]           product;
  logic                        accept;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  assign slab_count = (slots_per_slab == '0) ? sfla_pkg::SPS_W'(1) : slots_per_slab;
  assign slab_top = CMP_W'(slots_formatted) + CMP_W'(slab_count);
  assign slab_fits = (slab_top <= POOL_CMP);
  assign free_slot = CMP_W'(req.slot_number);
  assign free_in_pool = (free_slot < POOL_CMP);
  assign eff_size = (slot_bytes < sfla_pkg::MIN_SLOT_BYTES) ?
                    sfla_pkg::MIN_SLOT_BYTES : slot_bytes;
  assign product = PROD_W'(res_slot) * PROD_W'(eff_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_slab <= sfla_pkg::SPS_W'(64);
      slot_bytes <= sfla_pkg::SIZE_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfla_pkg::CFG_SLOTS_PER_SLAB: slots_per_slab <= cfg_data[sfla_pkg::SPS_W-1:0];
        sfla_pkg::CFG_SLOT_BYTES:     slot_bytes <= cfg_data[sfla_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_FMT) begin
      next_link[fmt_addr[IDX_W-1:0]] <= (fmt_addr == fmt_end) ?
                                        list_head : fmt_addr + LINK_W'(1);
    end else if (accept && req.req_type == sfla_pkg::REQ_FREE && free_in_pool) begin
      next_link[free_slot[IDX_W-1:0]] <= list_head;
    end
    if (state == S_RD) begin
      rd_data <= next_link[list_head[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      list_head <= EMPTY;
      slots_formatted <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == sfla_pkg::REQ_FREE) begin
              if (free_in_pool) begin
                list_head <= free_slot[LINK_W-1:0];
              end
              res_slot <= free_slot;
              res_status <= sfla_pkg::ST_FREED;
              state <= S_MUL;
            end else if (list_head != EMPTY) begin
              state <= S_RD;
            end else if (slab_fits) begin
              fmt_addr <= slots_formatted;
              fmt_end <= slab_top[LINK_W-1:0] - LINK_W'(1);
              state <= S_FMT;
            end else begin
              res_slot <= '0;
              res_status <= sfla_pkg::ST_OUT_OF_MEM;
              state <= S_MUL;
            end
          end
        end
        S_FMT: begin
          fmt_addr <= fmt_addr + LINK_W'(1);
          if (fmt_addr == fmt_end) begin
            list_head <= slots_formatted;
            slots_formatted <= fmt_end + LINK_W'(1);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_LINK;
        end
        S_LINK: begin
          res_slot <= CMP_W'(list_head);
          res_status <= sfla_pkg::ST_ALLOCATED;
          list_head <= rd_data;
          state <= S_MUL;
        end
        S_MUL: begin
          rsp.status <= res_status;
          rsp.granted_slot <= res_slot[sfla_pkg::SLOT_W-1:0];
          rsp.slot_address <= product[sfla_pkg::ADDR_W-1:0];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== verif/slab_alloc_checker.sv =====
`timescale 1ns / 100ps
module slab_alloc_checker #(
  parameter int unsigned POOL_SLOTS = 1024
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire                              busy,
  input  sfla_pkg::req_t                   req,
  input  wire                              done,
  input  sfla_pkg::rsp_t                   rsp,
  input  wire                              cfg_valid,
  input  wire                              cfg_ready,
  input  wire [sfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [sfla_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              wrap_up,
  output int                               errors
);

  localparam int unsigned LINK_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  // shadow of the allocator: link memory, list head, slots carved so far
  logic [LINK_W-1:0]           link_mem [POOL_SLOTS];
  logic [LINK_W-1:0]           free_head;
  logic [LINK_W-1:0]           carved;
  logic [sfla_pkg::SPS_W-1:0]  slab_slots;
  logic [sfla_pkg::SIZE_W-1:0] unit_bytes;
  sfla_pkg::rsp_t              pending_grants [$];

  initial errors = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns MISMATCH: %s", $realtime, msg);
  endtask

  function automatic logic [sfla_pkg::ADDR_W-1:0] byte_offset(
    input logic [sfla_pkg::SLOT_W-1:0] slot
  );
    logic [sfla_pkg::SIZE_W-1:0] sz;
    sz = (unit_bytes < sfla_pkg::MIN_SLOT_BYTES) ? sfla_pkg::MIN_SLOT_BYTES : unit_bytes;
    return sfla_pkg::ADDR_W'(slot) * sfla_pkg::ADDR_W'(sz);
  endfunction

  // chain the next slab in front of the list; 0 when the pool has no room
  function automatic bit carve_slab();
    int unsigned count;
    int unsigned base;
    int unsigned i;
    count = (slab_slots == '0) ? 1 : int'(slab_slots);
    base = 32'(carved);
    if (count > POOL_SLOTS - base) return 1'b0;
    for (i = 0; i + 1 < count; i++) link_mem[IDX_W'(base + i)] = LINK_W'(base + i + 1);
    link_mem[IDX_W'(base + count - 1)] = free_head;
    free_head = LINK_W'(base);
    carved = LINK_W'(base + count);
    return 1'b1;
  endfunction

  function automatic sfla_pkg::rsp_t predict_grant(input sfla_pkg::req_t r);
    sfla_pkg::rsp_t e;
    e = '0;
    if (r.req_type == sfla_pkg::REQ_ALLOC) begin
      if (free_head >= POOL_SLOTS && !carve_slab()) begin
        e.status = sfla_pkg::ST_OUT_OF_MEM;
        return e;
      end
      e.status = sfla_pkg::ST_ALLOCATED;
      e.granted_slot = sfla_pkg::SLOT_W'(free_head);
      free_head = link_mem[free_head[IDX_W-1:0]];
      e.slot_address = byte_offset(e.granted_slot);
    end else begin
      if (r.slot_number < POOL_SLOTS) begin
        link_mem[IDX_W'(r.slot_number)] = free_head;
        free_head = LINK_W'(r.slot_number);
      end
      e.status = sfla_pkg::ST_FREED;
      e.granted_slot = r.slot_number;
      e.slot_address = byte_offset(r.slot_number);
    end
    return e;
  endfunction

  always @(posedge clk) begin : watch
    sfla_pkg::rsp_t want;
    if (rst) begin
      free_head = LINK_W'(POOL_SLOTS);
      carved = '0;
      slab_slots = sfla_pkg::SPS_W'(64);
      unit_bytes = sfla_pkg::SIZE_W'(8);
      pending_grants.delete();
    end else begin
      // retire the answer first: a new request may be taken on the same edge
      if (done) begin
        if (pending_grants.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d slot %0d",
                                    rsp.status, rsp.granted_slot));
        end else begin
          want = pending_grants.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
          if (rsp.granted_slot !== want.granted_slot)
            report_mismatch($sformatf("slot %0d, want %0d",
                                      rsp.granted_slot, want.granted_slot));
          if (rsp.slot_address !== want.slot_address)
            report_mismatch($sformatf("address %0d, want %0d (slot %0d)",
                                      rsp.slot_address, want.slot_address,
                                      want.granted_slot));
        end
      end
      if (start && !busy) pending_grants.push_back(predict_grant(req));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfla_pkg::CFG_SLOTS_PER_SLAB: slab_slots = cfg_data[sfla_pkg::SPS_W-1:0];
          sfla_pkg::CFG_SLOT_BYTES:     unit_bytes = cfg_data[sfla_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (wrap_up && pending_grants.size() != 0)
        report_mismatch($sformatf("%0d requests never answered", pending_grants.size()));
    end
  end

endmodule

// ===== verif/tb_slab_free_list_allocator.sv =====
`timescale 1ns / 100ps
module tb_slab_free_list_allocator;

  localparam int unsigned POOL_SLOTS = 1024;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  sfla_pkg::req_t                  req = '0;
  logic                            cfg_valid = 1'b0;
  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            wrap_up = 1'b0;
  wire                             busy;
  wire                             done;
  wire                             cfg_ready;
  sfla_pkg::rsp_t                  rsp;
  int                              errors;

  int unsigned sent = 0;
  int unsigned answered = 0;
  int unsigned allocs_seen = 0;
  int unsigned frees_seen = 0;
  int unsigned ooms_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned settings = 0;
  int unsigned burst_left = 0;
  bit          keep_grants = 1'b0;
  logic [sfla_pkg::SLOT_W-1:0] held_slots [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  slab_free_list_allocator #(.POOL_SLOTS(POOL_SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slab_alloc_checker #(.POOL_SLOTS(POOL_SLOTS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wrap_up   (wrap_up),
    .errors    (errors)
  );

  // granted slots feed the well-formed frees
  always @(posedge clk) begin
    if (!rst && done) begin
      answered++;
      case (rsp.status)
        sfla_pkg::ST_ALLOCATED: begin
          allocs_seen++;
          if (keep_grants) held_slots.push_back(rsp.granted_slot);
        end
        sfla_pkg::ST_FREED:      frees_seen++;
        sfla_pkg::ST_OUT_OF_MEM: ooms_seen++;
        default: ;
      endcase
    end
  end

  task automatic issue(input logic kind, input logic [sfla_pkg::SLOT_W-1:0] slot);
    @(negedge clk);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    req <= '{req_type: kind, slot_number: slot};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // wait until every request is answered and the block is idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (sent != answered || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfla_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfla_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [sfla_pkg::CFG_DATA_W-1:0] sps,
                            input logic [sfla_pkg::CFG_DATA_W-1:0] sz);
    settle();
    write_reg(sfla_pkg::CFG_SLOTS_PER_SLAB, sps);
    write_reg(sfla_pkg::CFG_SLOT_BYTES, sz);
    settings++;
  endtask

  // noisy phases free arbitrary slots, so double frees can occur there
  task automatic run_phase(input int unsigned count, input int unsigned alloc_pct,
                           input bit noisy, input int unsigned oom_goal);
    int unsigned n;
    int unsigned pick;
    int unsigned oom_mark;
    logic [sfla_pkg::SLOT_W-1:0] s;
    oom_mark = ooms_seen;
    for (n = 0; n < count && (oom_goal == 0 || ooms_seen < oom_mark + oom_goal); n++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        issue(sfla_pkg::REQ_ALLOC, sfla_pkg::SLOT_W'($urandom));
      end else if (noisy) begin
        issue(sfla_pkg::REQ_FREE, sfla_pkg::SLOT_W'($urandom));
      end else if (held_slots.size() != 0) begin
        pick = $urandom_range(0, held_slots.size() - 1);
        s = held_slots[pick];
        held_slots.delete(pick);
        issue(sfla_pkg::REQ_FREE, s);
      end else begin
        issue(sfla_pkg::REQ_ALLOC, sfla_pkg::SLOT_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: free of a never-carved slot, then take it back
    issue(sfla_pkg::REQ_FREE, sfla_pkg::SLOT_W'(1023));
    issue(sfla_pkg::REQ_ALLOC, sfla_pkg::SLOT_W'(1023));
    // slab size field reads zero after masking -> one slot per slab; tiny slot size
    set_config(16'h0800, 16'd0);
    issue(sfla_pkg::REQ_ALLOC, '0);
    issue(sfla_pkg::REQ_ALLOC, '0);
    settle();
    write_reg(sfla_pkg::CFG_SLOT_BYTES, 16'd7);
    issue(sfla_pkg::REQ_FREE, sfla_pkg::SLOT_W'(1));
    issue(sfla_pkg::REQ_ALLOC, '0);
    issue(sfla_pkg::REQ_FREE, sfla_pkg::SLOT_W'(0));
    issue(sfla_pkg::REQ_ALLOC, '0);
    // slab larger than the pool, then one that no longer fits
    set_config(16'hFFFF, 16'hFFFF);
    issue(sfla_pkg::REQ_ALLOC, '0);
    settle();
    write_reg(sfla_pkg::CFG_SLOTS_PER_SLAB, 16'd1024);
    issue(sfla_pkg::REQ_ALLOC, '0);
    issue(sfla_pkg::REQ_FREE, sfla_pkg::SLOT_W'(1023));
    issue(sfla_pkg::REQ_ALLOC, '0);

    settle();
    keep_grants = 1'b1;
    set_config(16'd64, sfla_pkg::CFG_DATA_W'($urandom_range(8, 64)));
    run_phase(200, 65, 1'b0, 0);
    set_config(16'd1, 16'd8);
    run_phase(150, 70, 1'b0, 0);
    set_config(sfla_pkg::CFG_DATA_W'($urandom_range(2, 40)),
               sfla_pkg::CFG_DATA_W'($urandom));
    run_phase(200, 50, 1'b0, 0);
    set_config(sfla_pkg::CFG_DATA_W'($urandom_range(100, 400)),
               sfla_pkg::CFG_DATA_W'($urandom_range(8, 4096)));
    run_phase(150, 90, 1'b0, 0);
    // drain toward exhaustion until a run of out-of-memory answers shows up
    set_config(16'd1024, 16'hFFFF);
    run_phase(300, 95, 1'b0, 16);
    set_config(sfla_pkg::CFG_DATA_W'($urandom_range(0, 2047)),
               sfla_pkg::CFG_DATA_W'($urandom));
    run_phase(100, 50, 1'b1, 0);

    settle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    wrap_up <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    $display("Covered %0d requests: %0d allocations, %0d frees, %0d out-of-memory answers",
             sent, allocs_seen, frees_seen, ooms_seen);
    $display("%0d register writes over %0d slab/slot-size settings", reg_writes, settings);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d of %0d requests answered", answered, sent);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfla_pkg.sv
rtl/slab_free_list_allocator.sv
verif/slab_alloc_checker.sv
verif/tb_slab_free_list_allocator.sv
